// ===== rtl/nitt_pkg.sv =====
// Shared constants, widths and sideband types for the normal inverse-transpose transform.
// No dependencies; imported by every module of the block.
package nitt_pkg;

  localparam int unsigned OUT_FRAC_BITS = 16;
  localparam int unsigned OUT_W         = OUT_FRAC_BITS + 2;
  localparam int unsigned IN_W          = 32;
  localparam int unsigned IN_FIELDS     = 12;
  localparam int unsigned IN_TDATA_W    = IN_FIELDS * IN_W;
  localparam int unsigned OUT_TDATA_W   = ((3 * OUT_W + 7) / 8) * 8;
  localparam int unsigned COF_W         = 2 * IN_W;
  localparam int unsigned PP_W          = COF_W + IN_W;
  localparam int unsigned V_W           = PP_W + 2;
  localparam int unsigned MAG_W         = V_W - 1;
  localparam int unsigned NORM_BITS     = 30;
  localparam int unsigned CHUNK_W       = 8;
  localparam int unsigned CHUNKS        = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned BL_W          = $clog2(MAG_W + 1);
  localparam int unsigned CL_W          = $clog2(CHUNK_W + 1);
  localparam int unsigned SHIFT_W       = MAG_W + NORM_BITS;
  localparam int unsigned SQ_W          = 2 * NORM_BITS;
  localparam int unsigned SSUM_W        = SQ_W + 2;
  localparam int unsigned SQRT_STEPS    = SSUM_W / 2;
  localparam int unsigned LEN_W         = SQRT_STEPS;
  localparam int unsigned RW            = SSUM_W + 1;
  localparam int unsigned QW            = OUT_W;
  localparam int unsigned NUM_W         = NORM_BITS + OUT_FRAC_BITS + 1;
  localparam int unsigned DREM_W        = LEN_W + QW;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << OUT_FRAC_BITS;

  // Operand pairs of the cofactor products: cofactor k is P[2k] - P[2k+1].
  localparam int unsigned CF_A [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
  localparam int unsigned CF_B [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } ctl_t;

  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] u;
    ctl_t                      ctl;
  } sq_side_t;

endpackage

// ===== rtl/nitt_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband carried along.
// Depends on nitt_pkg.
module nitt_sqrt import nitt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SSUM_W-1:0] x_i,
  input  sq_side_t          side_i,
  output logic              valid_o,
  output logic [LEN_W-1:0]  root_o,
  output sq_side_t          side_o
);

  logic [RW-1:0]           rem_q  [SQRT_STEPS];
  logic [RW-1:0]           rem_d  [SQRT_STEPS];
  logic [RW-1:0]           root_q [SQRT_STEPS];
  logic [RW-1:0]           root_d [SQRT_STEPS];
  sq_side_t                side_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0]   valid_q;

  always_comb begin
    logic [RW-1:0] src_rem;
    logic [RW-1:0] src_root;
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      if (j == 0) begin
        src_rem  = RW'(x_i);
        src_root = '0;
      end else begin
        src_rem  = rem_q[j-1];
        src_root = root_q[j-1];
      end
      bitv  = RW'(1) << (SSUM_W - 2 - 2 * j);
      trial = src_root + bitv;
      if (src_rem >= trial) begin
        rem_d[j]  = src_rem - trial;
        root_d[j] = (src_root >> 1) + bitv;
      end else begin
        rem_d[j]  = src_rem;
        root_d[j] = src_root >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[SQRT_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
        side_q[j] <= (j == 0) ? side_i : side_q[j-1];
      end
    end
  end

  assign valid_o = valid_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1][LEN_W-1:0];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

// ===== rtl/nitt_div.sv =====
// Pipelined restoring divider for three numerators over one divisor, one quotient bit per stage.
// Depends on nitt_pkg.
module nitt_div import nitt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][NUM_W-1:0] num_i,
  input  logic [LEN_W-1:0]     len_i,
  input  ctl_t                 ctl_i,
  output logic                 valid_o,
  output logic [2:0][QW-1:0]   quo_o,
  output ctl_t                 ctl_o
);

  logic [2:0][DREM_W-1:0] rem_q [QW];
  logic [2:0][DREM_W-1:0] rem_d [QW];
  logic [2:0][QW-1:0]     quo_q [QW];
  logic [2:0][QW-1:0]     quo_d [QW];
  logic [LEN_W-1:0]       len_q [QW];
  ctl_t                   ctl_q [QW];
  logic [QW-1:0]          valid_q;

  always_comb begin
    logic [2:0][DREM_W-1:0] src_rem;
    logic [2:0][QW-1:0]     src_quo;
    logic [LEN_W-1:0]       src_len;
    logic [DREM_W-1:0]      dv;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        for (int k = 0; k < 3; k++) begin
          src_rem[k] = DREM_W'(num_i[k]);
        end
        src_quo = '0;
        src_len = len_i;
      end else begin
        src_rem = rem_q[s-1];
        src_quo = quo_q[s-1];
        src_len = len_q[s-1];
      end
      dv = DREM_W'(src_len) << (QW - 1 - s);
      for (int k = 0; k < 3; k++) begin
        if (src_rem[k] >= dv) begin
          rem_d[s][k] = src_rem[k] - dv;
          quo_d[s][k] = src_quo[k] | (QW'(1) << (QW - 1 - s));
        end else begin
          rem_d[s][k] = src_rem[k];
          quo_d[s][k] = src_quo[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        len_q[s] <= (s == 0) ? len_i : len_q[s-1];
        ctl_q[s] <= (s == 0) ? ctl_i : ctl_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign ctl_o   = ctl_q[QW-1];

endmodule

// ===== rtl/normal_inverse_transpose_transform.sv =====
// Normal transform by the inverse-transpose of a 3x3 matrix, normalized to unit length.
// The pipeline is 11 arithmetic stages, 31 square-root stages, a numerator stage,
// 18 divider stages and the output register. Throughput is one beat per cycle.
// The whole pipeline advances together and holds while a result waits at the output.
// Reset clears only the valid bits; the block is ready right after reset.
// Depends on nitt_pkg, nitt_sqrt and nitt_div.
module normal_inverse_transpose_transform import nitt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // mat_r0_c0 .. mat_r2_c2, obj_norm_x, obj_norm_y, obj_norm_z, 32 bits each.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // world_norm_x, world_norm_y, world_norm_z, zero padding.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // zero_length.
  output logic [0:0]             m_axis_tuser
);

  logic adv;
  logic [10:0] vld_q;
  logic vld12_q;
  logic out_vld_q;

  logic signed [IN_W-1:0]  mat   [9];
  logic signed [IN_W-1:0]  opnd0 [6];

  logic signed [COF_W-1:0] prod1_q [18];
  logic signed [IN_W-1:0]  opnd1_q [6];
  logic signed [COF_W-1:0] cof2_q  [9];
  logic signed [IN_W-1:0]  opnd2_q [6];
  logic signed [COF_W-1:0] pph3_q  [12];
  logic signed [COF_W:0]   ppl3_q  [12];
  logic signed [PP_W-1:0]  prod4_q [12];
  logic signed [V_W-1:0]   sum5_q  [4];
  logic [MAG_W-1:0]        mag6_d  [3];
  logic [MAG_W-1:0]        mag6_q  [3];
  logic [2:0]              neg6_d, neg6_q;
  logic [MAG_W-1:0]        mag7_q  [3];
  logic [2:0]              neg7_q;
  logic [CHUNKS-1:0]       nz7_d, nz7_q;
  logic [CL_W-1:0]         clen7_d [CHUNKS];
  logic [CL_W-1:0]         clen7_q [CHUNKS];
  logic [MAG_W-1:0]        mag8_q  [3];
  logic [2:0]              neg8_q;
  logic [BL_W-1:0]         blen8_d, blen8_q;
  logic [NORM_BITS-1:0]    u9_d    [3];
  sq_side_t                side9_q;
  logic [SQ_W-1:0]         sq10_q  [3];
  sq_side_t                side10_q;
  logic [SSUM_W-1:0]       ssum11_q;
  sq_side_t                side11_q;

  logic                    sqrt_vld;
  logic [LEN_W-1:0]        sqrt_root;
  sq_side_t                sqrt_side;

  logic [2:0][NUM_W-1:0]   num12_q;
  logic [LEN_W-1:0]        len12_q;
  ctl_t                    ctl12_q;

  logic                    div_vld;
  logic [2:0][QW-1:0]      div_quo;
  ctl_t                    div_ctl;

  logic [2:0][OUT_W-1:0]   out_d, out_q;
  logic                    zero_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mat[i] = s_axis_tdata[i*IN_W +: IN_W];
    end
    for (int i = 0; i < 3; i++) begin
      opnd0[i]   = s_axis_tdata[i*IN_W +: IN_W];
      opnd0[i+3] = s_axis_tdata[(i+9)*IN_W +: IN_W];
    end
  end

  always_comb begin
    logic signed [V_W-1:0] absv;
    for (int k = 0; k < 3; k++) begin
      absv      = sum5_q[k+1][V_W-1] ? -sum5_q[k+1] : sum5_q[k+1];
      mag6_d[k] = absv[MAG_W-1:0];
      neg6_d[k] = sum5_q[k+1][V_W-1] ^ sum5_q[0][V_W-1];
    end
  end

  always_comb begin
    logic [CHUNKS*CHUNK_W-1:0] orv;
    logic [CHUNK_W-1:0]        chunk;
    orv = (CHUNKS*CHUNK_W)'(mag6_q[0] | mag6_q[1] | mag6_q[2]);
    for (int c = 0; c < CHUNKS; c++) begin
      chunk      = orv[c*CHUNK_W +: CHUNK_W];
      nz7_d[c]   = |chunk;
      clen7_d[c] = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
        if (chunk[b]) begin
          clen7_d[c] = CL_W'(b + 1);
        end
      end
    end
  end

  always_comb begin
    blen8_d = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (nz7_q[c]) begin
        blen8_d = BL_W'(c * CHUNK_W) + BL_W'(clen7_q[c]);
      end
    end
  end

  always_comb begin
    logic [SHIFT_W-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      sh    = {mag8_q[k], {NORM_BITS{1'b0}}} >> blen8_q;
      u9_d[k] = sh[NORM_BITS-1:0];
    end
  end

  always_comb begin
    logic [QW-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = (div_quo[k] > ONE_Q) ? ONE_Q : div_quo[k];
      if (div_ctl.zero) begin
        out_d[k] = '0;
      end else if (div_ctl.neg[k]) begin
        out_d[k] = -q;
      end else begin
        out_d[k] = q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld12_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[9:0], s_axis_tvalid};
      vld12_q   <= sqrt_vld;
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < 18; p++) begin
        prod1_q[p] <= mat[CF_A[p]] * mat[CF_B[p]];
      end
      opnd1_q <= opnd0;

      for (int k = 0; k < 9; k++) begin
        cof2_q[k] <= prod1_q[2*k] - prod1_q[2*k+1];
      end
      opnd2_q <= opnd1_q;

      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 3; j++) begin
          pph3_q[r*3+j] <= $signed(cof2_q[((r == 0) ? 0 : r - 1) * 3 + j][COF_W-1:IN_W])
                           * opnd2_q[(r == 0) ? j : j + 3];
          ppl3_q[r*3+j] <= $signed({1'b0, cof2_q[((r == 0) ? 0 : r - 1) * 3 + j][IN_W-1:0]})
                           * opnd2_q[(r == 0) ? j : j + 3];
        end
      end

      for (int p = 0; p < 12; p++) begin
        prod4_q[p] <= $signed({pph3_q[p], {IN_W{1'b0}}}) + PP_W'(ppl3_q[p]);
      end

      for (int r = 0; r < 4; r++) begin
        sum5_q[r] <= V_W'(prod4_q[r*3]) + V_W'(prod4_q[r*3+1]) + V_W'(prod4_q[r*3+2]);
      end

      mag6_q  <= mag6_d;
      neg6_q  <= neg6_d;

      mag7_q  <= mag6_q;
      neg7_q  <= neg6_q;
      nz7_q   <= nz7_d;
      clen7_q <= clen7_d;

      mag8_q  <= mag7_q;
      neg8_q  <= neg7_q;
      blen8_q <= blen8_d;

      for (int k = 0; k < 3; k++) begin
        side9_q.u[k] <= u9_d[k];
      end
      side9_q.ctl.neg  <= neg8_q;
      side9_q.ctl.zero <= (blen8_q == '0);

      for (int k = 0; k < 3; k++) begin
        sq10_q[k] <= SQ_W'(side9_q.u[k]) * SQ_W'(side9_q.u[k]);
      end
      side10_q <= side9_q;

      ssum11_q <= SSUM_W'(sq10_q[0]) + SSUM_W'(sq10_q[1]) + SSUM_W'(sq10_q[2]);
      side11_q <= side10_q;

      for (int k = 0; k < 3; k++) begin
        num12_q[k] <= (NUM_W'(sqrt_side.u[k]) << OUT_FRAC_BITS) + NUM_W'(sqrt_root >> 1);
      end
      len12_q <= sqrt_root;
      ctl12_q <= sqrt_side.ctl;

      out_q  <= out_d;
      zero_q <= div_ctl.zero;
    end
  end

  nitt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[10]),
    .x_i     (ssum11_q),
    .side_i  (side11_q),
    .valid_o (sqrt_vld),
    .root_o  (sqrt_root),
    .side_o  (sqrt_side)
  );

  nitt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld12_q),
    .num_i   (num12_q),
    .len_i   (len12_q),
    .ctl_i   (ctl12_q),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .ctl_o   (div_ctl)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q[2], out_q[1], out_q[0]});
  assign m_axis_tuser  = zero_q;

endmodule
